// ===== rtl/bcd_datetime_to_epoch_ms_top_assert.svh =====
// ----------------------------------------------------------------------------
// bcd datetime to epoch ms assertion macros
// shared property forms for the checker of the converter
// ----------------------------------------------------------------------------
`ifndef BCD_DATETIME_TO_EPOCH_MS_TOP_ASSERT_SVH
`define BCD_DATETIME_TO_EPOCH_MS_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define BDTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BDTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define BDTE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bdte_pkg.sv =====
// ----------------------------------------------------------------------------
// bdte_pkg
// constants and helpers of the bcd date/time to epoch milliseconds converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdte_pkg;

  // stream widths
  localparam int unsigned IN_BYTES   = 6;
  localparam int unsigned IN_WIDTH   = IN_BYTES * 8;
  localparam int unsigned OUT_FIELD  = 43;
  localparam int unsigned OUT_WIDTH  = ((OUT_FIELD + 7) / 8) * 8;

  // calendar constants
  localparam int unsigned YEAR_OFS     = 2000;
  localparam int unsigned YOE_LAST     = 399;
  localparam int unsigned DAYS_YEAR    = 365;
  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned EPOCH_SHIFT  = 719468;
  localparam int unsigned SEC_DAY      = 86400;
  localparam int unsigned SEC_HOUR     = 3600;
  localparam int unsigned SEC_MIN      = 60;
  localparam int unsigned MS_SEC       = 1000;
  localparam int unsigned TZ_SEC       = 8 * SEC_HOUR;
  localparam int unsigned MDAY_MUL     = 153;
  localparam int unsigned MDAY_ADD     = 2;

  // reciprocal for divide by 5 (exact below 2^16) and by 100 (exact below 1000)
  localparam int unsigned RCP5_MUL     = 52429;
  localparam int unsigned RCP5_SHIFT   = 18;
  localparam int unsigned RCP100_MUL   = 41;
  localparam int unsigned RCP100_SHIFT = 12;

  // day count offsets for the two eras that can occur (modulo 2^20)
  localparam int DAYS_W         = 20;
  localparam int ERA4_OFS       = 4 * ERA_DAYS - EPOCH_SHIFT;
  localparam int ERA5_OFS       = 5 * ERA_DAYS - EPOCH_SHIFT;

  // packed bcd byte, weighted as it stands
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// ===== rtl/bcd_datetime_to_epoch_ms_top.sv =====
// ----------------------------------------------------------------------------
// bcd_datetime_to_epoch_ms_top
// converts a packed bcd local (utc+8) date and time into unix milliseconds
// ----------------------------------------------------------------------------
// Usage: an input beat on s_axis carries six packed bcd bytes (year offset
// from 2000, month, day, hour, minute, second, lowest byte first). Each beat
// gives exactly one output beat on m_axis with the milliseconds since
// 1970-01-01 00:00 utc in the low 43 bits of tdata.
// The block is a seven-stage pipeline (bcd decode, era and month shift,
// reciprocal divides, day count, day-to-second multiply, second sum,
// millisecond multiply) and accepts one beat every cycle while the
// output is not stalled.
// Reset clears all stage valid bits; no beat is in flight afterward.
// When the receiver holds m_axis_tready low with a beat waiting, the whole
// pipeline holds and s_axis_tready drops in the same cycle; nothing is lost
// or repeated, and the pipeline resumes as soon as the output is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_datetime_to_epoch_ms_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // year, month, day, hour, minute, second (one bcd byte each)
  input  logic [bdte_pkg::IN_WIDTH-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // utc_milliseconds [42:0], zero fill above
  output logic [bdte_pkg::OUT_WIDTH-1:0] m_axis_tdata
);

  // global advance: hold everything while the output beat waits
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      v5            <= 1'b0;
      v6            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      v5            <= v4;
      v6            <= v5;
      m_axis_tvalid <= v6;
    end
  end

  // stage 1: bcd decode
  logic [7:0] s1_year, s1_month, s1_day, s1_hour, s1_min, s1_sec;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_year  <= bdte_pkg::bcd_dec(s_axis_tdata[7:0]);
      s1_month <= bdte_pkg::bcd_dec(s_axis_tdata[15:8]);
      s1_day   <= bdte_pkg::bcd_dec(s_axis_tdata[23:16]);
      s1_hour  <= bdte_pkg::bcd_dec(s_axis_tdata[31:24]);
      s1_min   <= bdte_pkg::bcd_dec(s_axis_tdata[39:32]);
      s1_sec   <= bdte_pkg::bcd_dec(s_axis_tdata[47:40]);
    end
  end

  // stage 2: march-based year, era, year of era, month term, time of day
  logic        s1_early;
  logic        era5_next;
  logic [8:0]  yoe_next;
  logic [7:0]  mshift_next;
  logic        s2_era5;
  logic [8:0]  s2_yoe;
  logic [14:0] s2_mterm;
  logic [19:0] s2_hms;
  logic [7:0]  s2_day;

  always_comb begin
    s1_early    = (s1_month <= 8'd2);
    era5_next   = !((s1_year == 8'd0) && s1_early);
    yoe_next    = era5_next ? ({1'b0, s1_year} - {8'd0, s1_early})
                            : 9'(bdte_pkg::YOE_LAST);
    mshift_next = s1_early ? (s1_month + 8'd9) : (s1_month - 8'd3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_era5  <= era5_next;
      s2_yoe   <= yoe_next;
      s2_mterm <= 15'({7'd0, mshift_next} * 15'(bdte_pkg::MDAY_MUL))
                  + 15'(bdte_pkg::MDAY_ADD);
      s2_hms   <= 20'({12'd0, s1_hour} * 20'(bdte_pkg::SEC_HOUR))
                  + 20'({12'd0, s1_min} * 20'(bdte_pkg::SEC_MIN))
                  + {12'd0, s1_sec};
      s2_day   <= s1_day;
    end
  end

  // stage 3: divide by 5 and by 100 through reciprocals, years to days
  logic [30:0] q5_prod;
  logic [13:0] q100_prod;
  logic        s3_era5;
  logic [12:0] s3_mdays;
  logic [17:0] s3_y365;
  logic [6:0]  s3_y4;
  logic [1:0]  s3_y100;
  logic [19:0] s3_hms;
  logic [7:0]  s3_day;

  always_comb begin
    q5_prod   = {16'd0, s2_mterm} * 31'(bdte_pkg::RCP5_MUL);
    q100_prod = {5'd0, s2_yoe} * 14'(bdte_pkg::RCP100_MUL);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_era5  <= s2_era5;
      s3_mdays <= q5_prod[bdte_pkg::RCP5_SHIFT +: 13];
      s3_y365  <= {9'd0, s2_yoe} * 18'(bdte_pkg::DAYS_YEAR);
      s3_y4    <= s2_yoe[8:2];
      s3_y100  <= q100_prod[bdte_pkg::RCP100_SHIFT +: 2];
      s3_hms   <= s2_hms;
      s3_day   <= s2_day;
    end
  end

  // stage 4: days since the epoch (wraps modulo 2^20, true value is positive)
  logic [bdte_pkg::DAYS_W-1:0] days_sum;
  logic [16:0]                 s4_days;
  logic [19:0]                 s4_hms;

  always_comb begin
    days_sum = {2'd0, s3_y365} + {13'd0, s3_y4} - {18'd0, s3_y100}
             + {7'd0, s3_mdays} + {12'd0, s3_day} - 20'd1
             + (s3_era5 ? bdte_pkg::DAYS_W'(bdte_pkg::ERA5_OFS)
                        : bdte_pkg::DAYS_W'(bdte_pkg::ERA4_OFS));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_days <= days_sum[16:0];
      s4_hms  <= s3_hms;
    end
  end

  // stage 5: days to seconds
  logic [33:0] s5_dsec;
  logic [19:0] s5_hms;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_dsec <= {17'd0, s4_days} * 34'(bdte_pkg::SEC_DAY);
      s5_hms  <= s4_hms;
    end
  end

  // stage 6: add time of day, take off the zone offset
  logic [33:0] s6_secs;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_secs <= s5_dsec + {14'd0, s5_hms} - 34'(bdte_pkg::TZ_SEC);
    end
  end

  // stage 7: seconds to milliseconds, output register
  logic [43:0] ms_prod;

  assign ms_prod = s6_secs[33:0] * 44'(bdte_pkg::MS_SEC);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {{(bdte_pkg::OUT_WIDTH - bdte_pkg::OUT_FIELD){1'b0}},
                       ms_prod[bdte_pkg::OUT_FIELD-1:0]};
    end
  end

endmodule

// ===== rtl/bdte_checker.sv =====
// ----------------------------------------------------------------------------
// bdte_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bcd_datetime_to_epoch_ms_top_assert.svh"

module bdte_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bdte_pkg::OUT_WIDTH-1:0] m_axis_tdata
);

  // a waiting output beat holds until taken
  `BDTE_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // input side is ready exactly when the pipeline advances
  `BDTE_ASSERT_NOW(a_ready_adv, clk, rst, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")

  // no output beat is valid right after reset
  `BDTE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid, "output valid right after reset")

endmodule

bind bcd_datetime_to_epoch_ms_top bdte_checker u_bdte_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// bcd local date/time to unix milliseconds converter, self-checking
// ----------------------------------------------------------------------------
// Directed stamps cover field extremes, non-decimal nibbles, early and late
// months, day zero and overflowing times. Random stamps follow: mostly valid
// dates, some with one scrambled byte, and some fully random bytes. Every
// accepted input beat is run through a calendar predictor. Each output beat
// is checked in order against the oldest predicted value. Source and sink
// back-pressure change in three load phases, and before some phases the
// source waits for the pipeline to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IN_W  = bdte_pkg::IN_WIDTH;
  localparam int unsigned OUT_W = bdte_pkg::OUT_WIDTH;
  localparam int RANDOM_STAMPS  = 1050;
  localparam int SETTLE_CYCLES  = 20;

  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FREE
  } load_phase_t;

  typedef struct {
    logic [IN_W-1:0] bytes;
    load_phase_t     phase;
    bit              drain_first;
  } stamp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // year, month, day, hour, minute, second (one bcd byte each)
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // utc_milliseconds [42:0], zero fill above
  logic [OUT_W-1:0] m_axis_tdata;

  stamp_t           stamp_q[$];
  logic [42:0]      epoch_ms_q[$];
  load_phase_t      load_phase = PH_SLOW_SINK;
  logic             pipe_empty = 1'b1;
  int               mismatch_count = 0;

  bcd_datetime_to_epoch_ms_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected milliseconds for one stamp, days counted from a march-based year
  function automatic logic [42:0] predict_utc_ms(input logic [IN_W-1:0] stamp);
    longint fld[6];
    longint yr;
    longint mo;
    longint era;
    longint yoe;
    longint doy;
    longint doe;
    longint days;
    longint secs;
    for (int i = 0; i < 6; i++) begin
      fld[i] = longint'(stamp[8*i+4 +: 4]) * 10 + longint'(stamp[8*i +: 4]);
    end
    mo   = fld[1];
    // january and february belong to the previous march-based year
    yr   = 2000 + fld[0] - ((mo <= 2) ? 1 : 0);
    era  = yr / 400;
    yoe  = yr - era * 400;
    doy  = (153 * (mo + ((mo > 2) ? -3 : 9)) + 2) / 5 + fld[2] - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    // local utc+8 to utc
    secs = days * 86400 + fld[3] * 3600 + fld[4] * 60 + fld[5] - 8 * 3600;
    return 43'(secs * 1000);
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // idle share in percent for the source or the sink in a load phase
  function automatic int unsigned idle_share(input load_phase_t ph, input bit sink);
    case (ph)
      PH_SLOW_SINK:   return sink ? 76 : 13;
      PH_SLOW_SOURCE: return sink ? 13 : 76;
      default:        return 0;
    endcase
  endfunction

  task automatic add_stamp(input logic [7:0] yr, input logic [7:0] mo,
                           input logic [7:0] dy, input logic [7:0] hr,
                           input logic [7:0] mi, input logic [7:0] se,
                           input load_phase_t ph, input bit drain);
    stamp_t st;
    st.bytes       = {se, mi, hr, dy, mo, yr};
    st.phase       = ph;
    st.drain_first = drain;
    stamp_q.push_back(st);
  endtask

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s expected %h actual %h", $realtime, what, want, got);
    end
  endtask

  // source side: present the next stamp, hold it until taken
  always @(posedge clk) begin
    stamp_t head;
    bit     present;
    present = 1'b0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stamp_q.size() != 0) begin
        head = stamp_q[0];
        if (head.drain_first && (s_axis_tvalid || !pipe_empty)) begin
          present = 1'b0;
        end else begin
          present = ($urandom_range(0, 99) >= idle_share(head.phase, 1'b0));
        end
      end
      if (present) begin
        s_axis_tdata <= head.bytes;
        load_phase   <= head.phase;
        void'(stamp_q.pop_front());
      end
      s_axis_tvalid <= present;
    end
  end

  // sink side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_share(load_phase, 1'b1));
    end
  end

  // check output beats first, then record the prediction for an input beat
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (epoch_ms_q.size() == 0) begin
          note_mismatch("beat with nothing pending", '0, m_axis_tdata);
        end else begin
          want = OUT_W'(epoch_ms_q.pop_front());
          if (m_axis_tdata !== want) begin
            note_mismatch("utc_milliseconds", want, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        epoch_ms_q.push_back(predict_utc_ms(s_axis_tdata));
      end
      pipe_empty <= (epoch_ms_q.size() == 0);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  f[6];
    load_phase_t ph;

    // era boundaries and a leap day
    add_stamp(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h00, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59, PH_SLOW_SINK, 1'b0);
    // all-zero, all-ones and all-nines bytes
    add_stamp(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, PH_SLOW_SINK, 1'b0);
    // month zero and february fold into the previous year
    add_stamp(8'h24, 8'h00, 8'h15, 8'h08, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h24, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    // months past december, one of them non-decimal
    add_stamp(8'h24, 8'h13, 8'h01, 8'h10, 8'h20, 8'h30, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h24, 8'hAF, 8'h10, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    // day zero and a day past the month end
    add_stamp(8'h23, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h23, 8'h02, 8'h31, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    // time fields out of range and non-decimal nibbles
    add_stamp(8'h23, 8'h06, 8'h15, 8'h24, 8'h60, 8'h60, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h23, 8'h06, 8'h15, 8'h0F, 8'h0F, 8'h0F, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h23, 8'h06, 8'h15, 8'hF0, 8'hF0, 8'hF0, PH_SLOW_SINK, 1'b0);
    add_stamp(8'hA5, 8'h07, 8'h04, 8'h12, 8'h34, 8'h56, PH_SLOW_SINK, 1'b0);
    // local time before 08:00 falls on the previous utc day
    add_stamp(8'h00, 8'h01, 8'h01, 8'h07, 8'h59, 8'h59, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h25, 8'h07, 8'h04, 8'h08, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h25, 8'h12, 8'h31, 8'h00, 8'h00, 8'h00, PH_SLOW_SINK, 1'b0);
    add_stamp(8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h96, 8'h69, PH_SLOW_SINK, 1'b0);

    // random stamps: valid dates, valid dates with one raw byte, raw bytes
    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      kind = $urandom_range(0, 99);
      f[0] = to_bcd($urandom_range(0, 99));
      f[1] = to_bcd($urandom_range(1, 12));
      f[2] = to_bcd($urandom_range(1, 28));
      f[3] = to_bcd($urandom_range(0, 23));
      f[4] = to_bcd($urandom_range(0, 59));
      f[5] = to_bcd($urandom_range(0, 59));
      if (kind >= 87) begin
        for (int j = 0; j < 6; j++) f[j] = 8'($urandom);
      end else if (kind >= 72) begin
        pick = $urandom_range(0, 5);
        f[pick] = 8'($urandom);
      end
      ph = (i < RANDOM_STAMPS / 3)     ? PH_SLOW_SINK :
           (i < 2 * RANDOM_STAMPS / 3) ? PH_SLOW_SOURCE : PH_FREE;
      add_stamp(f[0], f[1], f[2], f[3], f[4], f[5], ph,
                (i == 0) || (i == RANDOM_STAMPS / 3) || (i == 2 * RANDOM_STAMPS / 3));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait until every stamp is sent and every result is back
    @(negedge clk);
    while (stamp_q.size() != 0 || s_axis_tvalid || !pipe_empty) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bdte_pkg.sv
rtl/bcd_datetime_to_epoch_ms_top.sv
rtl/bdte_checker.sv
verif/testbench.sv
